>>> sv/slist_pkg.sv
// shared types and constants for the sorted list block
package slist_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_PREV,
      RD_CUR,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      idx_op_type idx_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_rdata;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_pos;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     idx_zero;
      logic     idx_at_count;
      logic     next_at_end;
      logic     full;
      logic     empty;
      logic     rd_gt;
      logic     rd_eq;
   } stat_type;

endpackage

>>> sv/slist_ram.sv
// generic single write port ram with registered read
module slist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/slist_dp.sv
// datapath: entry memory, index and count registers, result registers
module slist_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [slist_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [slist_pkg::DATA_W-1:0] req_value,
   input  slist_pkg::cmd_type              cmd,
   output slist_pkg::stat_type             stat,
   output logic [slist_pkg::STAT_W-1:0]    rsp_status,
   output logic [slist_pkg::POS_W-1:0]     rsp_position,
   output logic [slist_pkg::COUNT_W-1:0]   rsp_count
);
   import slist_pkg::*;

   mode_type                 mode_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W:0]           idx_next;
   logic [CNT_W-1:0]         rd_idx;
   logic [DATA_W-1:0]        rd_data;
   logic [DATA_W-1:0]        wr_data;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [POS_W-1:0]         rsp_position_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   assign idx_next = {1'b0, idx_ff} + {{CNT_W{1'b0}}, 1'b1};

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_idx = idx_ff - {{(CNT_W-1){1'b0}}, 1'b1};
         RD_NEXT: rd_idx = idx_next[CNT_W-1:0];
         default: rd_idx = idx_ff;
      endcase
   end

   assign wr_data = cmd.wr_rdata ? rd_data : value_ff;

   slist_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(idx_ff[IDX_W-1:0]),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_idx[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      if (cmd.load) begin
         idx_in = (mode_type'(req_mode) == MODE_INSERT) ? count_ff : '0;
      end else begin
         unique case (cmd.idx_op)
            IDX_INC: idx_in = idx_next[CNT_W-1:0];
            IDX_DEC: idx_in = idx_ff - {{(CNT_W-1){1'b0}}, 1'b1};
            default: idx_in = idx_ff;
         endcase
      end
   end

   always_comb begin
      priority if (cmd.count_inc) begin
         count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (cmd.count_dec) begin
         count_in = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff   <= cmd.rsp_status;
         rsp_position_ff <= cmd.rsp_pos ? POS_W'(idx_ff) : '0;
         rsp_count_ff    <= COUNT_W'(count_in);
      end
   end

   assign stat.mode         = mode_ff;
   assign stat.idx_zero     = (idx_ff == '0);
   assign stat.idx_at_count = (idx_ff == count_ff);
   assign stat.next_at_end  = (idx_next >= {1'b0, count_ff});
   assign stat.full         = (count_ff == CNT_W'(DEPTH));
   assign stat.empty        = (count_ff == '0);
   assign stat.rd_gt        = ($signed(rd_data) > value_ff);
   assign stat.rd_eq        = ($signed(rd_data) == value_ff);

   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

>>> sv/slist_ctrl.sv
// controller: sequences insert, search and remove over the entry memory
module slist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   input  slist_pkg::stat_type stat,
   output slist_pkg::cmd_type  cmd
);
   import slist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_CMP,
      S_FIND_RD,
      S_FIND_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff;

   always_comb begin
      cmd        = '0;
      cmd.idx_op = IDX_HOLD;
      cmd.rd_sel = RD_CUR;
      cmd.rsp_status = ST_OK;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.mode)
               MODE_INSERT: begin
                  if (stat.full) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_FULL;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               MODE_SEARCH, MODE_REMOVE: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_FIND_RD;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_INS_RD: begin
            if (stat.idx_zero) begin
               cmd.wr_en     = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_pos   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // walk down from the tail, moving larger entries up one slot
            cmd.wr_en = 1'b1;
            if (stat.rd_gt) begin
               cmd.wr_rdata = 1'b1;
               cmd.idx_op   = IDX_DEC;
               state_in     = S_INS_RD;
            end else begin
               cmd.count_inc = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_pos   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FIND_RD: begin
            if (stat.idx_at_count) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
               state_in   = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (stat.rd_eq) begin
               if (stat.mode == MODE_SEARCH) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_pos  = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_FIND_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.next_at_end) begin
               cmd.count_dec = 1'b1;
               cmd.rsp_load  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            // close the gap left by the removed entry
            cmd.wr_en    = 1'b1;
            cmd.wr_rdata = 1'b1;
            cmd.idx_op   = IDX_INC;
            state_in     = S_SHIFT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

endmodule

>>> sv/sorted_list_insert_search_remove.sv
// top level of the bounded ascending sorted list
//
//   channel   ports                                  transfer when
//   request   start, busy, req_mode, req_value      start high and busy low
//   result    rsp_strobe, rsp_status, rsp_position,  rsp_strobe high
//             rsp_count
//
// one operation at a time over an entry memory with one write port and one read port;
// each entry is read, then compared, written or both.
// a full list on insert, an empty list on search or remove, and the unused mode end in decode.
// the result strobe is registered from the last step and comes in the cycle after it; busy is already low then.
// synchronous reset empties the list; the memory needs no clearing pass.
module sorted_list_insert_search_remove (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [slist_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [slist_pkg::DATA_W-1:0] req_value,
   output logic                                rsp_strobe,
   output logic [slist_pkg::STAT_W-1:0]        rsp_status,
   output logic [slist_pkg::POS_W-1:0]         rsp_position,
   output logic [slist_pkg::COUNT_W-1:0]       rsp_count
);
   import slist_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   slist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .stat      (stat),
      .cmd       (cmd)
   );

   slist_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_status  (rsp_status),
      .rsp_position(rsp_position),
      .rsp_count   (rsp_count)
   );

endmodule
